FILE: sv/assert_macros.svh
// assertion macros shared by the layer normalization rtl
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/lnorm_pkg.sv
// types and constants for the layer normalization block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lnorm_pkg;

  typedef logic signed [15:0] q88_t;
  typedef logic [23:0] inv_t;

  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_APPLY      = 1'b1;

  localparam inv_t INV_MAX = 24'hFF_FFFF;
  localparam logic [15:0] EPS_RESET = 16'd1;
  localparam int RECIP_SHIFT = 48;

  localparam q88_t Q88_MAX = 16'sh7FFF;
  localparam q88_t Q88_MIN = 16'sh8000;

endpackage

`default_nettype wire

FILE: sv/layer_normalization.sv
// Layer normalization of one feature row in signed Q8.8, two passes. An accumulate
// transaction (command 0) forms the square in the accept cycle and updates the exact
// sums in the next. The accumulate transaction with row_end then runs the row
// statistics on one shared compare/subtract unit, one bit (divide) or two bits (square
// root) per cycle over DVW bits, DVW being max(31 + clog2(MAX_ELEMENTS+1), 50) rounded
// up to even. An apply transaction (command 1) uses the shared multiplier in the accept
// cycle and in S_AP_MUL, then waits in S_AP_OUT while the output register still holds
// an untaken result. in_ready is low while a transaction is being worked on. cfg_wr_en
// writes variance_epsilon (reset 1).
// depends on lnorm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module layer_normalization
  import lnorm_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_wr_en,
  input  wire         [15:0] cfg_wr_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                in_command,
  input  wire  signed [15:0] in_sample_value,
  input  wire  signed [15:0] in_scale_gamma,
  input  wire  signed [15:0] in_shift_beta,
  input  wire                in_row_end,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [15:0] out_normalized_value,
  output logic               out_clipped,
  output logic               out_row_last
);

  localparam int CW   = $clog2(MAX_ELEMENTS + 1);
  localparam int SUMW = 16 + CW;
  localparam int SQW  = 31 + CW;
  localparam int DVW0 = (SQW > 50) ? SQW : 50;
  localparam int DVW  = DVW0 + (DVW0 % 2);
  localparam int IW   = $clog2(DVW);

  localparam logic [DVW-1:0] RECIP_ONE = DVW'(1) << RECIP_SHIFT;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ACC_ADD  = 4'd1;
  localparam logic [3:0] S_FIN      = 4'd2;
  localparam logic [3:0] S_DIV_MEAN = 4'd3;
  localparam logic [3:0] S_MEAN     = 4'd4;
  localparam logic [3:0] S_DIV_MSQ  = 4'd5;
  localparam logic [3:0] S_SQM      = 4'd6;
  localparam logic [3:0] S_VAR      = 4'd7;
  localparam logic [3:0] S_RECIP    = 4'd8;
  localparam logic [3:0] S_DIV_RCP  = 4'd9;
  localparam logic [3:0] S_SQRT     = 4'd10;
  localparam logic [3:0] S_INV      = 4'd11;
  localparam logic [3:0] S_AP_MUL   = 4'd12;
  localparam logic [3:0] S_AP_OUT   = 4'd13;

  logic [3:0]             state_r, state_nxt;
  logic [15:0]            eps_r, eps_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic signed [SUMW-1:0] sum_r, sum_nxt;
  logic [SQW-1:0]         sumsq_r, sumsq_nxt;
  q88_t                   mean_r, mean_nxt;
  inv_t                   inv_r, inv_nxt;
  q88_t                   v_r, v_nxt, g_r, g_nxt, b_r, b_nxt;
  logic                   last_r, last_nxt;
  logic signed [49:0]     prod_r, prod_nxt;
  logic [DVW-1:0]         dvd_r, dvd_nxt;
  logic [31:0]            rem_r, rem_nxt;
  logic [31:0]            div_r, div_nxt;
  logic [24:0]            root_r, root_nxt;
  logic [31:0]            var_r, var_nxt;
  logic [IW-1:0]          it_r, it_nxt;
  logic                   out_valid_r, out_valid_nxt;
  q88_t                   out_val_r, out_val_nxt;
  logic                   out_clip_r, out_clip_nxt;
  logic                   out_last_r, out_last_nxt;

  // shared compare/subtract unit
  logic [32:0] sub_a, sub_b;
  logic [33:0] sub_diff;
  logic        sub_ge;
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[33];

  // shared multiplier
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic              in_fire;
  logic signed [16:0] in_diff;
  logic [SUMW-1:0]   sum_abs;
  logic [SUMW:0]     quo_x;
  logic [SUMW:0]     mean_full;
  logic              rem_nz;
  logic signed [32:0] y_full;
  logic [31:0]       var_pos;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_diff   = {in_sample_value[15], in_sample_value} - {mean_r[15], mean_r};
  assign sum_abs   = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
  assign quo_x     = {1'b0, dvd_r[SUMW-1:0]};
  assign rem_nz    = (rem_r != 32'd0);
  assign mean_full = sum_r[SUMW-1] ? (~quo_x + (SUMW + 1)'(!rem_nz)) : quo_x;
  assign y_full    = $signed({prod_r[39], prod_r[39:8]}) + $signed({{17{b_r[15]}}, b_r});
  assign var_pos   = (sub_diff[33] ? 32'd0 : sub_diff[31:0]) + {16'd0, eps_r};

  always_comb begin
    sub_a = 33'd0;
    sub_b = 33'd0;
    unique case (state_r)
      S_DIV_MEAN, S_DIV_MSQ, S_DIV_RCP: begin
        sub_a = {rem_r, dvd_r[DVW-1]};
        sub_b = {1'b0, div_r};
      end
      S_SQRT: begin
        sub_a = {rem_r[30:0], dvd_r[DVW-1 -: 2]};
        sub_b = {6'd0, root_r, 2'b01};
      end
      S_VAR: begin
        sub_a = dvd_r[32:0];
        sub_b = prod_r[32:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mul_a = 25'sd0;
    mul_b = 25'sd0;
    unique case (state_r)
      S_IDLE: begin
        if (in_command == CMD_APPLY) begin
          mul_a = {{8{in_diff[16]}}, in_diff};
          mul_b = {1'b0, inv_r};
        end else begin
          mul_a = {{9{in_sample_value[15]}}, in_sample_value};
          mul_b = {{9{in_sample_value[15]}}, in_sample_value};
        end
      end
      S_SQM: begin
        mul_a = {{9{mean_r[15]}}, mean_r};
        mul_b = {{9{mean_r[15]}}, mean_r};
      end
      S_AP_MUL: begin
        mul_a = prod_r[40:16];
        mul_b = {{9{g_r[15]}}, g_r};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    eps_nxt       = cfg_wr_en ? cfg_wr_data : eps_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    mean_nxt      = mean_r;
    inv_nxt       = inv_r;
    v_nxt         = v_r;
    g_nxt         = g_r;
    b_nxt         = b_r;
    last_nxt      = last_r;
    prod_nxt      = prod_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    root_nxt      = root_r;
    var_nxt       = var_r;
    it_nxt        = it_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_clip_nxt  = out_clip_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          v_nxt    = in_sample_value;
          g_nxt    = in_scale_gamma;
          b_nxt    = in_shift_beta;
          last_nxt = in_row_end;
          prod_nxt = mul_p;
          if (in_command == CMD_APPLY) begin
            state_nxt = S_AP_MUL;
          end else if (count_r < CW'(MAX_ELEMENTS)) begin
            state_nxt = S_ACC_ADD;
          end else if (in_row_end) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_ACC_ADD: begin
        sum_nxt   = sum_r + {{(SUMW - 16){v_r[15]}}, v_r};
        sumsq_nxt = sumsq_r + {{(SQW - 31){1'b0}}, prod_r[30:0]};
        count_nxt = count_r + CW'(1);
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        dvd_nxt   = DVW'(sum_abs);
        div_nxt   = {{(32 - CW){1'b0}}, count_r};
        rem_nxt   = 32'd0;
        it_nxt    = '0;
        state_nxt = S_DIV_MEAN;
      end
      S_DIV_MEAN, S_DIV_MSQ, S_DIV_RCP: begin
        dvd_nxt = {dvd_r[DVW-2:0], sub_ge};
        rem_nxt = sub_ge ? sub_diff[31:0] : sub_a[31:0];
        it_nxt  = it_r + IW'(1);
        if (it_r == IW'(DVW - 1)) begin
          it_nxt = '0;
          unique case (state_r)
            S_DIV_MEAN: state_nxt = S_MEAN;
            S_DIV_MSQ:  state_nxt = S_SQM;
            default: begin
              rem_nxt   = 32'd0;
              root_nxt  = 25'd0;
              state_nxt = S_SQRT;
            end
          endcase
        end
      end
      S_MEAN: begin
        mean_nxt  = mean_full[15:0];
        dvd_nxt   = DVW'(sumsq_r);
        rem_nxt   = 32'd0;
        it_nxt    = '0;
        count_nxt = '0;
        sum_nxt   = '0;
        sumsq_nxt = '0;
        state_nxt = S_DIV_MSQ;
      end
      S_SQM: begin
        prod_nxt  = mul_p;
        state_nxt = S_VAR;
      end
      S_VAR: begin
        var_nxt   = var_pos;
        state_nxt = S_RECIP;
      end
      S_RECIP: begin
        if (var_r == 32'd0) begin
          inv_nxt   = INV_MAX;
          state_nxt = S_IDLE;
        end else begin
          dvd_nxt   = RECIP_ONE;
          div_nxt   = var_r;
          rem_nxt   = 32'd0;
          it_nxt    = '0;
          state_nxt = S_DIV_RCP;
        end
      end
      S_SQRT: begin
        dvd_nxt  = {dvd_r[DVW-3:0], 2'b00};
        rem_nxt  = sub_ge ? sub_diff[31:0] : sub_a[31:0];
        root_nxt = {root_r[23:0], sub_ge};
        it_nxt   = it_r + IW'(1);
        if (it_r == IW'(DVW / 2 - 1)) begin
          state_nxt = S_INV;
        end
      end
      S_INV: begin
        inv_nxt   = root_r[24] ? INV_MAX : root_r[23:0];
        state_nxt = S_IDLE;
      end
      S_AP_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_AP_OUT;
      end
      S_AP_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = last_r;
          if (y_full > 33'sd32767) begin
            out_val_nxt  = Q88_MAX;
            out_clip_nxt = 1'b1;
          end else if (y_full < -33'sd32768) begin
            out_val_nxt  = Q88_MIN;
            out_clip_nxt = 1'b1;
          end else begin
            out_val_nxt  = y_full[15:0];
            out_clip_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eps_r       <= EPS_RESET;
      count_r     <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      mean_r      <= '0;
      inv_r       <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      eps_r       <= eps_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      sumsq_r     <= sumsq_nxt;
      mean_r      <= mean_nxt;
      inv_r       <= inv_nxt;
      it_r        <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    g_r        <= g_nxt;
    b_r        <= b_nxt;
    last_r     <= last_nxt;
    prod_r     <= prod_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    root_r     <= root_nxt;
    var_r      <= var_nxt;
    out_val_r  <= out_val_nxt;
    out_clip_r <= out_clip_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_normalized_value = out_val_r;
  assign out_clipped          = out_clip_r;
  assign out_row_last         = out_last_r;

  // saturation flag only on a rail value
  `ASSERT_IMP(a_clip_rail, clk, rst_n, out_valid && out_clipped, (out_normalized_value == Q88_MAX) || (out_normalized_value == Q88_MIN))
  // statistics cleared once the mean is taken
  `ASSERT_NXT(a_sums_cleared, clk, rst_n, state_r == S_MEAN, (count_r == '0) && (sum_r == '0) && (sumsq_r == '0))
  // a finished row never leaves a zero inverse deviation
  `ASSERT_NXT(a_inv_nonzero, clk, rst_n, state_r == S_INV, inv_r != 24'd0)
  // square root remainder stays within twice the partial root
  `ASSERT_IMP(a_sqrt_rem, clk, rst_n, state_r == S_SQRT, rem_r <= {6'd0, root_r, 1'b0})

endmodule

`default_nettype wire

FILE: bench/layer_norm_checker.sv
// checker for layer_normalization: keeps its own row statistics, predicts every apply result
// and compares it field by field with the output transaction; depends on lnorm_pkg
`timescale 1ns / 1ps

module layer_norm_checker
  import lnorm_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_command,
  input  q88_t        in_sample_value,
  input  q88_t        in_scale_gamma,
  input  q88_t        in_shift_beta,
  input  logic        in_row_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  q88_t        out_normalized_value,
  input  logic        out_clipped,
  input  logic        out_row_last,
  output int          fail_count,
  output int          results_pending,
  output int          results_checked
);

  typedef struct packed {
    q88_t value;
    logic clipped;
    logic last;
  } norm_result_t;

  norm_result_t    pending_norm[$];
  logic [15:0]     epsilon;
  int              elem_count;
  longint          row_sum;
  longint unsigned row_sq_sum;
  q88_t            row_mean;
  inv_t            inv_dev;
  int              mismatches;
  int              checked;

  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem = x;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // mean, clamped variance and inverse deviation of the finished row
  function automatic void close_row();
    longint          quot;
    longint unsigned avg_sq;
    longint unsigned mean_sq;
    longint unsigned var_eps;
    longint unsigned root;
    quot = row_sum / longint'(elem_count);
    if ((row_sum % longint'(elem_count)) != 0 && row_sum < 0) quot = quot - 1;
    row_mean = q88_t'(quot);
    avg_sq = row_sq_sum / 64'(elem_count);
    mean_sq = 64'(quot * quot);
    var_eps = (avg_sq > mean_sq) ? avg_sq - mean_sq : 64'd0;
    var_eps = var_eps + 64'(epsilon);
    if (var_eps == 0) begin
      inv_dev = INV_MAX;
    end else begin
      root = root_floor((64'd1 << RECIP_SHIFT) / var_eps);
      inv_dev = (root > 64'(INV_MAX)) ? INV_MAX : inv_t'(root);
    end
    elem_count = 0;
    row_sum = 0;
    row_sq_sum = 0;
  endfunction

  function automatic norm_result_t normalize_element(input q88_t val, input q88_t gamma,
                                                     input q88_t beta, input logic last);
    longint       diff;
    longint       scaled;
    longint       y;
    norm_result_t r;
    diff = longint'(val) - longint'(row_mean);
    scaled = (diff * longint'(inv_dev)) >>> 16;
    y = ((scaled * longint'(gamma)) >>> 8) + longint'(beta);
    r.clipped = 1'b1;
    if (y > longint'(Q88_MAX)) begin
      r.value = Q88_MAX;
    end else if (y < longint'(Q88_MIN)) begin
      r.value = Q88_MIN;
    end else begin
      r.value = q88_t'(y);
      r.clipped = 1'b0;
    end
    r.last = last;
    return r;
  endfunction

  always @(posedge clk) begin
    norm_result_t want;
    if (!rst_n) begin
      epsilon = EPS_RESET;
      elem_count = 0;
      row_sum = 0;
      row_sq_sum = 0;
      row_mean = '0;
      inv_dev = '0;
      pending_norm.delete();
    end else begin
      // output side first: a result at this edge was produced by an earlier transaction
      if (out_valid && out_ready) begin
        if (pending_norm.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %0d clipped %0b last %0b",
                     out_normalized_value, out_clipped, out_row_last);
        end else begin
          want = pending_norm.pop_front();
          checked++;
          if (out_normalized_value !== want.value || out_clipped !== want.clipped ||
              out_row_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected value %0d clipped %0b last %0b, got %0d %0b %0b",
                       checked, want.value, want.clipped, want.last,
                       out_normalized_value, out_clipped, out_row_last);
          end
        end
      end
      if (cfg_wr_en) epsilon = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (in_command == CMD_ACCUMULATE) begin
          if (elem_count < MAX_ELEMENTS) begin
            row_sum = row_sum + longint'(in_sample_value);
            row_sq_sum = row_sq_sum +
                         64'(longint'(in_sample_value) * longint'(in_sample_value));
            elem_count++;
          end
          if (in_row_end && elem_count > 0) close_row();
        end else begin
          pending_norm.push_back(normalize_element(in_sample_value, in_scale_gamma,
                                                   in_shift_beta, in_row_end));
        end
      end
    end
    fail_count <= mismatches;
    results_pending <= pending_norm.size();
    results_checked <= checked;
  end

endmodule

FILE: bench/tb_layer_normalization.sv
// top of the layer_normalization testbench: clock, reset, epsilon writes and stimulus
// depends on lnorm_pkg, layer_normalization and layer_norm_checker
`timescale 1ns / 1ps

module tb_layer_normalization;
  import lnorm_pkg::*;

  localparam int MAX_ELEMENTS  = 1024;
  localparam int ITEM_GOAL     = 1650;
  localparam int SETTLE_CYCLES = 250;
  localparam int STALL_LIMIT   = 4000;

  typedef enum int {MODE_FULL, MODE_CLUSTER, MODE_EXTREME, MODE_CONSTANT} sample_mode_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = CMD_ACCUMULATE;
  q88_t        in_sample_value = '0;
  q88_t        in_scale_gamma = '0;
  q88_t        in_shift_beta = '0;
  logic        in_row_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  q88_t        out_normalized_value;
  logic        out_clipped;
  logic        out_row_last;

  int fail_count;
  int results_pending;
  int results_checked;
  int send_idle_pct = 7;
  int recv_idle_pct = 75;
  int items_sent;
  int accumulate_sent;
  int apply_sent;
  int rows_sent;
  int stall_cycles;

  layer_normalization #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_sample_value     (in_sample_value),
    .in_scale_gamma      (in_scale_gamma),
    .in_shift_beta       (in_shift_beta),
    .in_row_end          (in_row_end),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_normalized_value(out_normalized_value),
    .out_clipped         (out_clipped),
    .out_row_last        (out_row_last)
  );

  layer_norm_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_sample_value     (in_sample_value),
    .in_scale_gamma      (in_scale_gamma),
    .in_shift_beta       (in_shift_beta),
    .in_row_end          (in_row_end),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_normalized_value(out_normalized_value),
    .out_clipped         (out_clipped),
    .out_row_last        (out_row_last),
    .fail_count          (fail_count),
    .results_pending     (results_pending),
    .results_checked     (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_element(input logic cmd, input q88_t val, input q88_t gamma,
                              input q88_t beta, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_sample_value <= val;
    in_scale_gamma <= gamma;
    in_shift_beta <= beta;
    in_row_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (cmd == CMD_APPLY) apply_sent++;
    else accumulate_sent++;
  endtask

  function automatic q88_t pick_sample(input sample_mode_t mode, input q88_t center,
                                       input int spread);
    case (mode)
      MODE_FULL: return q88_t'($urandom);
      MODE_CLUSTER: return q88_t'(int'(center) + int'($urandom_range(2 * spread)) - spread);
      MODE_EXTREME: begin
        case ($urandom_range(3))
          0: return Q88_MIN;
          1: return Q88_MAX;
          2: return q88_t'(0);
          default: return q88_t'(-1);
        endcase
      end
      default: return center;
    endcase
  endfunction

  function automatic q88_t pick_gamma();
    case ($urandom_range(3))
      0: return q88_t'($urandom);
      1: return q88_t'(int'($urandom_range(128)) - 64);
      default: return q88_t'($urandom_range(512));
    endcase
  endfunction

  function automatic q88_t pick_beta();
    if ($urandom_range(1)) return q88_t'($urandom);
    return q88_t'(int'($urandom_range(1024)) - 512);
  endfunction

  // statistics pass then apply pass over values drawn from one distribution
  task automatic stream_row(input int n_acc, input int n_apl);
    sample_mode_t mode;
    q88_t         center;
    int           spread;
    mode = sample_mode_t'($urandom_range(3));
    center = q88_t'($urandom);
    spread = 1 << $urandom_range(12);
    for (int i = 0; i < n_acc; i++)
      send_element(CMD_ACCUMULATE, pick_sample(mode, center, spread), q88_t'($urandom),
                   q88_t'($urandom), i == n_acc - 1);
    for (int i = 0; i < n_apl; i++)
      send_element(CMD_APPLY, pick_sample(mode, center, spread), pick_gamma(), pick_beta(),
                   i == n_apl - 1);
    rows_sent++;
  endtask

  task automatic set_epsilon(input logic [15:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    // a row close produces no result, so give it time to finish
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [15:0] eps_plan [6];
    int          seg_end;
    int          roll;
    int          n;
    eps_plan = '{16'd0, 16'hFFFF, 16'($urandom), 16'd1, 16'($urandom),
                 16'($urandom_range(15))};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // apply before any statistics returns beta
    send_element(CMD_APPLY, Q88_MAX, Q88_MAX, Q88_MIN, 1'b1);
    // constant row: zero variance, inverse saturates
    send_element(CMD_ACCUMULATE, Q88_MIN, 16'sd0, 16'sd0, 1'b0);
    send_element(CMD_ACCUMULATE, Q88_MIN, Q88_MAX, Q88_MIN, 1'b0);
    send_element(CMD_ACCUMULATE, Q88_MIN, 16'sd0, 16'sd0, 1'b1);
    send_element(CMD_APPLY, Q88_MAX, Q88_MAX, Q88_MAX, 1'b0);
    send_element(CMD_APPLY, Q88_MAX, Q88_MIN, Q88_MIN, 1'b0);
    send_element(CMD_APPLY, Q88_MIN, 16'sd0, 16'sd12345, 1'b1);
    // floor of the mean drives the variance negative
    send_element(CMD_ACCUMULATE, -16'sd1, 16'sd0, 16'sd0, 1'b0);
    send_element(CMD_ACCUMULATE, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_element(CMD_APPLY, -16'sd1, 16'sd256, 16'sd0, 1'b0);
    send_element(CMD_APPLY, 16'sd0, 16'sd256, 16'sd0, 1'b1);
    // full-scale spread
    send_element(CMD_ACCUMULATE, Q88_MIN, 16'sd0, 16'sd0, 1'b0);
    send_element(CMD_ACCUMULATE, Q88_MAX, 16'sd0, 16'sd0, 1'b1);
    send_element(CMD_APPLY, Q88_MIN, 16'sd256, 16'sd0, 1'b0);
    send_element(CMD_APPLY, Q88_MAX, Q88_MAX, 16'sd0, 1'b1);
    // single element row
    send_element(CMD_ACCUMULATE, 16'sh1234, 16'sd0, 16'sd0, 1'b1);
    send_element(CMD_APPLY, 16'sh1234, -16'sd256, 16'sh00FF, 1'b1);

    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 75;
        recv_idle_pct = 7;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_epsilon(eps_plan[seg]);
      // one row longer than the statistics can hold
      if (seg == 5) stream_row(MAX_ELEMENTS + $urandom_range(6, 1), $urandom_range(16, 1));
      seg_end = (seg == 5) ? ITEM_GOAL : items_sent + 100;
      while (items_sent < seg_end) begin
        roll = $urandom_range(99);
        n = $urandom_range(16, 1);
        if (roll < 10) begin
          send_element(logic'($urandom_range(1)), q88_t'($urandom), q88_t'($urandom),
                       q88_t'($urandom), logic'($urandom_range(1)));
        end else if (roll < 14) begin
          stream_row(0, n);
        end else if (roll < 20) begin
          stream_row(n, $urandom_range(16, 1));
        end else begin
          stream_row(n, n);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d transactions in %0d rows (%0d accumulate, %0d apply), %0d results",
             items_sent, rows_sent, accumulate_sent, apply_sent, results_checked);
    $display("epsilon at reset value, 0, 65535 and random; three idling mixes; one long row");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/lnorm_pkg.sv
sv/layer_normalization.sv
bench/layer_norm_checker.sv
bench/tb_layer_normalization.sv
